@@ hdl/vapa_pkg.sv @@
package vapa_pkg;

  localparam int ADDR_W    = 30;
  localparam int SIZE_W    = 11;
  localparam int CODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 11;
  localparam int NUM_AXES  = 3;

  // cycles of input stall after reset or a register write, while the
  // derived strides settle through the three config stages
  localparam int BUSY_CYCLES = 4;
  localparam int BUSY_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS2  = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_RST  = 11'd1;
  localparam logic [CODE_W-1:0] AXIS0_RST = 3'sd1;
  localparam logic [CODE_W-1:0] AXIS1_RST = 3'sd2;
  localparam logic [CODE_W-1:0] AXIS2_RST = 3'sd3;
  localparam logic [CODE_W-1:0] CODE_ZERO = 3'b000;
  localparam logic [CODE_W-1:0] CODE_NEG4 = 3'b100;

  // per-cell traversal settings: offset at position 0 and the increment
  // applied on each advance (already negated for a reversed axis)
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] step;
  } cell_cfg_t;

endpackage

@@ hdl/vapa_cfg.sv @@
module vapa_cfg import vapa_pkg::*; #(
  parameter int MAX_EXTENT = 1024,
  parameter int EW         = 11,
  parameter int PW         = 10
) (
  input  logic              clk,
  input  logic [SIZE_W-1:0] size [NUM_AXES],
  input  logic [CODE_W-1:0] code [NUM_AXES],
  output logic [PW-1:0]     ext_m1 [NUM_AXES],
  output cell_cfg_t         cell_cfg [NUM_AXES],
  output logic              bad
);

  // stage 1: clamp extents, decode codes, destination sizes
  logic [EW-1:0] ext_c [NUM_AXES];
  logic [1:0]    abs_c [NUM_AXES];
  logic          neg_c [NUM_AXES];
  logic [EW-1:0] dn_c  [NUM_AXES];
  logic          bad_c;

  logic [EW-1:0] ext1_r [NUM_AXES];
  logic [EW-1:0] dn1_r  [NUM_AXES];
  logic [1:0]    abs1_r [NUM_AXES];
  logic          neg1_r [NUM_AXES];
  logic          bad1_r;

  always_comb begin
    logic [31:0]       sz;
    logic [CODE_W-1:0] mag;
    bad_c = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sz = 32'(size[i]);
      if (sz == 32'd0) begin
        ext_c[i] = EW'(1);
      end else if (sz > 32'(MAX_EXTENT)) begin
        ext_c[i] = EW'(MAX_EXTENT);
      end else begin
        ext_c[i] = EW'(sz);
      end
      neg_c[i] = code[i][CODE_W-1];
      mag      = neg_c[i] ? (~code[i] + CODE_W'(1)) : code[i];
      abs_c[i] = mag[1:0];
      if (code[i] == CODE_ZERO || code[i] == CODE_NEG4) begin
        bad_c = 1'b1;
      end
    end
    if (abs_c[0] == abs_c[1] || abs_c[0] == abs_c[2] || abs_c[1] == abs_c[2]) begin
      bad_c = 1'b1;
    end
    for (int j = 0; j < NUM_AXES; j++) begin
      case (abs_c[j])
        2'd2:    dn_c[j] = ext_c[1];
        2'd3:    dn_c[j] = ext_c[2];
        default: dn_c[j] = ext_c[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ext1_r <= ext_c;
    dn1_r  <= dn_c;
    abs1_r <= abs_c;
    neg1_r <= neg_c;
    bad1_r <= bad_c;
  end

  // stage 2: destination strides 1, dn0, dn0*dn1
  logic [ADDR_W-1:0] stride2_r [NUM_AXES];
  logic [EW-1:0]     ext2_r    [NUM_AXES];
  logic [1:0]        abs2_r    [NUM_AXES];
  logic              neg2_r    [NUM_AXES];
  logic              bad2_r;

  always_ff @(posedge clk) begin
    stride2_r[0] <= ADDR_W'(1);
    stride2_r[1] <= ADDR_W'(dn1_r[0]);
    stride2_r[2] <= ADDR_W'(dn1_r[0] * dn1_r[1]);
    ext2_r       <= ext1_r;
    abs2_r       <= abs1_r;
    neg2_r       <= neg1_r;
    bad2_r       <= bad1_r;
  end

  // stage 3: per source axis, pick its destination stride and direction
  logic [ADDR_W-1:0] sel_stride [NUM_AXES];
  logic              sel_neg    [NUM_AXES];
  cell_cfg_t         cfg_c      [NUM_AXES];

  always_comb begin
    logic [ADDR_W-1:0] span;
    for (int s = 0; s < NUM_AXES; s++) begin
      sel_stride[s] = '0;
      sel_neg[s]    = 1'b0;
      for (int j = 0; j < NUM_AXES; j++) begin
        if (abs2_r[j] == 2'(s + 1)) begin
          sel_stride[s] = stride2_r[j];
          sel_neg[s]    = neg2_r[j];
        end
      end
      span = ADDR_W'(ADDR_W'(ext2_r[s] - EW'(1)) * sel_stride[s]);
      if (bad2_r) begin
        cfg_c[s] = '0;
      end else if (sel_neg[s]) begin
        cfg_c[s].start = span;
        cfg_c[s].step  = ~sel_stride[s] + ADDR_W'(1);
      end else begin
        cfg_c[s].start = '0;
        cfg_c[s].step  = sel_stride[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NUM_AXES; s++) begin
      ext_m1[s] <= PW'(ext2_r[s] - EW'(1));
    end
    cell_cfg <= cfg_c;
    bad      <= bad2_r;
  end

endmodule

@@ hdl/vapa_cell.sv @@
module vapa_cell import vapa_pkg::*; #(
  parameter int PW = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic              advance,
  input  logic [PW-1:0]     ext_m1,
  input  cell_cfg_t         cfg,
  output logic [ADDR_W-1:0] offset,
  output logic              is_last,
  output logic              carry_out
);

  logic [PW-1:0]     pos_r, pos_nxt;
  logic [ADDR_W-1:0] offset_r, offset_nxt;

  assign is_last   = (pos_r == ext_m1);
  assign carry_out = advance & is_last;
  assign offset    = offset_r;

  always_comb begin
    pos_nxt    = pos_r;
    offset_nxt = offset_r;
    if (restart) begin
      pos_nxt    = '0;
      offset_nxt = cfg.start;
    end else if (advance) begin
      if (is_last) begin
        pos_nxt    = '0;
        offset_nxt = cfg.start;
      end else begin
        pos_nxt    = pos_r + PW'(1);
        offset_nxt = offset_r + cfg.step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      offset_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

@@ hdl/volume_axis_permute_addresser_core.sv @@
// An accepted item's result is registered on the output register in the next cycle.
// Throughput: 1 item per cycle while in_stall is low; the x/y/z cell chain steps its counters and
// offsets in the same cycle as the item is taken.
// Reset (synchronous, rst_n low) and every write to a size or axis register restart
// the volume at voxel 0 and stall the input while the strides are rederived.
module volume_axis_permute_addresser_core import vapa_pkg::*; #(
  parameter int MAX_EXTENT    = 1024,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DW-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ELEMENT_WIDTH-1:0] in_sample_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ELEMENT_WIDTH-1:0] out_sample_out,
  output logic [ADDR_W-1:0]        out_dest_address,
  output logic                     out_last_voxel,
  output logic                     out_config_error
);

  localparam int EW     = $clog2(MAX_EXTENT + 1);
  localparam int PW     = $clog2(MAX_EXTENT);
  localparam int KEEP_W = (ELEMENT_WIDTH < 16) ? ELEMENT_WIDTH : 16;

  logic [SIZE_W-1:0] size_r [NUM_AXES];
  logic [CODE_W-1:0] code_r [NUM_AXES];
  logic [BUSY_W-1:0] busy_cnt_r;
  logic              busy;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign busy      = (busy_cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0]  <= SIZE_RST;
      size_r[1]  <= SIZE_RST;
      size_r[2]  <= SIZE_RST;
      code_r[0]  <= AXIS0_RST;
      code_r[1]  <= AXIS1_RST;
      code_r[2]  <= AXIS2_RST;
      busy_cnt_r <= BUSY_W'(BUSY_CYCLES);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE_X: begin
            size_r[0]  <= cfg_data[SIZE_W-1:0];
            busy_cnt_r <= BUSY_W'(BUSY_CYCLES);
          end
          REG_SIZE_Y: begin
            size_r[1]  <= cfg_data[SIZE_W-1:0];
            busy_cnt_r <= BUSY_W'(BUSY_CYCLES);
          end
          REG_SIZE_Z: begin
            size_r[2]  <= cfg_data[SIZE_W-1:0];
            busy_cnt_r <= BUSY_W'(BUSY_CYCLES);
          end
          REG_AXIS0: begin
            code_r[0]  <= cfg_data[CODE_W-1:0];
            busy_cnt_r <= BUSY_W'(BUSY_CYCLES);
          end
          REG_AXIS1: begin
            code_r[1]  <= cfg_data[CODE_W-1:0];
            busy_cnt_r <= BUSY_W'(BUSY_CYCLES);
          end
          REG_AXIS2: begin
            code_r[2]  <= cfg_data[CODE_W-1:0];
            busy_cnt_r <= BUSY_W'(BUSY_CYCLES);
          end
          default: begin
            if (busy) begin
              busy_cnt_r <= busy_cnt_r - BUSY_W'(1);
            end
          end
        endcase
      end else if (busy) begin
        busy_cnt_r <= busy_cnt_r - BUSY_W'(1);
      end
    end
  end

  logic [PW-1:0] ext_m1 [NUM_AXES];
  cell_cfg_t     cell_cfg [NUM_AXES];
  logic          bad;

  vapa_cfg #(
    .MAX_EXTENT (MAX_EXTENT),
    .EW         (EW),
    .PW         (PW)
  ) u_cfg (
    .clk      (clk),
    .size     (size_r),
    .code     (code_r),
    .ext_m1   (ext_m1),
    .cell_cfg (cell_cfg),
    .bad      (bad)
  );

  logic              in_accept;
  logic              adv   [NUM_AXES+1];
  logic [ADDR_W-1:0] offs  [NUM_AXES];
  logic              lasts [NUM_AXES];

  assign in_stall  = busy | (out_valid & out_stall);
  assign in_accept = in_valid & ~in_stall;
  assign adv[0]    = in_accept;

  // x cell advances on every item, each further cell on the carry of the last
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_cell
    vapa_cell #(.PW(PW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .restart   (busy),
      .advance   (adv[g]),
      .ext_m1    (ext_m1[g]),
      .cfg       (cell_cfg[g]),
      .offset    (offs[g]),
      .is_last   (lasts[g]),
      .carry_out (adv[g+1])
    );
  end

  logic [ADDR_W-1:0] addr_sum;
  assign addr_sum = offs[0] + offs[1] + offs[2];

  logic                     out_valid_r;
  logic [ELEMENT_WIDTH-1:0] sample_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     last_r;
  logic                     err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= ELEMENT_WIDTH'(in_sample_in[KEEP_W-1:0]);
      addr_r   <= bad ? '0 : addr_sum;
      last_r   <= lasts[0] & lasts[1] & lasts[2];
      err_r    <= bad;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_out   = sample_r;
  assign out_dest_address = addr_r;
  assign out_last_voxel   = last_r;
  assign out_config_error = err_r;

endmodule

@@ hdl/vapa_checker.sv @@
module vapa_checker import vapa_pkg::*; #(
  parameter int ELEMENT_WIDTH = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic [CFG_IDX_W-1:0]     cfg_index,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [ELEMENT_WIDTH-1:0] out_sample_out,
  input logic [ADDR_W-1:0]        out_dest_address,
  input logic                     out_last_voxel,
  input logic                     out_config_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dest_address)
      && $stable(out_sample_out) && $stable(out_last_voxel))
    else $error("stalled result item changed");

  a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_config_error |-> out_dest_address == '0)
    else $error("address not zero on configuration error");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y
      || cfg_index == REG_SIZE_Z || cfg_index == REG_AXIS0
      || cfg_index == REG_AXIS1 || cfg_index == REG_AXIS2)
      |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
    else $error("input not stalled while strides are rederived");

endmodule

bind volume_axis_permute_addresser_core vapa_checker #(
  .ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_vapa_checker (.*);
